### hw/rtl/tkps_pkg.sv
// Shared constants, types and register codes for the top-k map peak selector.
package tkps_pkg;

  // Storage sizing
  localparam int MAP_CELLS   = 4096;
  localparam int MAX_WINNERS = 16;

  // Fixed field widths
  localparam int VAL_W     = 16;
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int WC_W      = 5;
  localparam int DIM_LIMIT = 64;
  localparam int CELL_W    = 12;

  // Derived widths
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int LOAD_W    = $clog2(MAP_CELLS + 1);
  localparam int CNT_W     = $clog2(MAX_WINNERS + 1);
  localparam int WIN_IDX_W = (MAX_WINNERS > 1) ? $clog2(MAX_WINNERS) : 1;

  // APB register map
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_WINNER_COUNT = 2'd2;

  // Reset values of the registers
  localparam logic [DIM_W-1:0] RST_MAP_WIDTH    = 7'd20;
  localparam logic [DIM_W-1:0] RST_MAP_HEIGHT   = 7'd15;
  localparam logic [WC_W-1:0]  RST_WINNER_COUNT = 5'd5;

  // Effective frame settings after clamping
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [CNT_W-1:0] count;
  } frame_cfg_t;

  // One cell visited by the sweep
  typedef struct packed {
    logic              vld;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CELL_W-1:0]  cell_idx;
    logic               in_map;
  } scan_t;

  // Pass control from the sequencer to the compare unit
  typedef struct packed {
    logic frame_start;
    logic emit;
    logic last;
  } pass_ctl_t;

endpackage

### hw/rtl/tkps_sweep.sv
// Pass sequencer: walks x outer, y inner over the map, once per winner.
module tkps_sweep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                launch,
  input  tkps_pkg::frame_cfg_t cfg,
  output tkps_pkg::scan_t     scan,
  output tkps_pkg::pass_ctl_t ctl,
  output logic                busy
);
  import tkps_pkg::*;

  typedef enum logic [3:0] {
    SW_IDLE  = 4'b0001,
    SW_SCAN  = 4'b0010,
    SW_DRAIN = 4'b0100,
    SW_EMIT  = 4'b1000
  } sw_state_t;

  sw_state_t          state_r, state_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic               empty_map;
  logic               y_end;
  logic               x_end;
  logic               last_pass;

  assign empty_map = (cfg.width == '0) || (cfg.height == '0);
  assign y_end     = ({1'b0, y_r} == cfg.height - DIM_W'(1));
  assign x_end     = ({1'b0, x_r} == cfg.width - DIM_W'(1));
  assign last_pass = (k_r == cfg.count - CNT_W'(1));

  // Sequence the passes
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cell_nxt  = cell_r;
    k_nxt     = k_r;
    case (state_r)
      SW_IDLE: begin
        if (launch && (cfg.count != '0)) begin
          x_nxt     = '0;
          y_nxt     = '0;
          cell_nxt  = '0;
          k_nxt     = '0;
          state_nxt = empty_map ? SW_DRAIN : SW_SCAN;
        end
      end
      SW_SCAN: begin
        if (y_end) begin
          y_nxt = '0;
          if (x_end) begin
            state_nxt = SW_DRAIN;
          end else begin
            x_nxt    = x_r + COORD_W'(1);
            cell_nxt = CELL_W'(x_r) + CELL_W'(1);
          end
        end else begin
          y_nxt    = y_r + COORD_W'(1);
          cell_nxt = cell_r + CELL_W'(cfg.width);
        end
      end
      SW_DRAIN: begin
        state_nxt = SW_EMIT;
      end
      SW_EMIT: begin
        if (last_pass) begin
          state_nxt = SW_IDLE;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          x_nxt     = '0;
          y_nxt     = '0;
          cell_nxt  = '0;
          state_nxt = empty_map ? SW_DRAIN : SW_SCAN;
        end
      end
      default: begin
        state_nxt = SW_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SW_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    cell_r <= cell_nxt;
  end

  // Present the current cell and pass control
  assign scan.vld      = (state_r == SW_SCAN);
  assign scan.x        = x_r;
  assign scan.y        = y_r;
  assign scan.cell_idx = cell_r;
  assign scan.in_map   = (32'(cell_r) < 32'(MAP_CELLS));

  assign ctl.frame_start = (state_r == SW_IDLE) && launch && (cfg.count != '0);
  assign ctl.emit        = (state_r == SW_EMIT);
  assign ctl.last        = (state_r == SW_EMIT) && last_pass;

  assign busy = (state_r != SW_IDLE);

endmodule

### hw/rtl/tkps_peak.sv
// Shared compare unit: tracks the best unchosen cell of a pass and the chosen list.
module tkps_peak (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tkps_pkg::scan_t               scan,
  input  tkps_pkg::pass_ctl_t           ctl,
  input  logic [tkps_pkg::VAL_W-1:0]    rd_data,
  output logic [tkps_pkg::COORD_W-1:0]  win_x,
  output logic [tkps_pkg::COORD_W-1:0]  win_y,
  output logic                          found
);
  import tkps_pkg::*;

  scan_t              s1_r;
  logic               s1_chosen_r;
  logic               chosen_hit;
  logic [CELL_W-1:0]  chosen_r [MAX_WINNERS];
  logic [CNT_W-1:0]   chosen_cnt_r;
  logic               have_r;
  logic [VAL_W-1:0]   best_val_r;
  logic [COORD_W-1:0] best_x_r;
  logic [COORD_W-1:0] best_y_r;
  logic [CELL_W-1:0]  best_cell_r;
  logic               take;

  // Match the current cell against the cells chosen so far this frame
  always_comb begin
    chosen_hit = 1'b0;
    for (int i = 0; i < MAX_WINNERS; i++) begin
      if ((CNT_W'(i) < chosen_cnt_r) && (chosen_r[i] == scan.cell_idx)) begin
        chosen_hit = 1'b1;
      end
    end
  end

  // Hold the cell alongside the registered map read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= scan.vld;
    end
    s1_r.x        <= scan.x;
    s1_r.y        <= scan.y;
    s1_r.cell_idx <= scan.cell_idx;
    s1_r.in_map   <= scan.in_map;
    s1_chosen_r   <= chosen_hit;
  end

  // Strict greater-than keeps the first cell in scan order on ties
  assign take = s1_r.vld && s1_r.in_map && !s1_chosen_r &&
                (!have_r || (rd_data > best_val_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.emit) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
    if (take) begin
      best_val_r  <= rd_data;
      best_x_r    <= s1_r.x;
      best_y_r    <= s1_r.y;
      best_cell_r <= s1_r.cell_idx;
    end
  end

  // Clear the chosen list per frame, append each winner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chosen_cnt_r <= '0;
    end else if (ctl.frame_start) begin
      chosen_cnt_r <= '0;
    end else if (ctl.emit && have_r) begin
      chosen_cnt_r <= chosen_cnt_r + CNT_W'(1);
    end
    if (ctl.emit && have_r) begin
      chosen_r[chosen_cnt_r[WIN_IDX_W-1:0]] <= best_cell_r;
    end
  end

  assign win_x = have_r ? best_x_r : '0;
  assign win_y = have_r ? best_y_r : '0;
  assign found = have_r;

  // The chosen list grows by one per found winner and never overflows
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(chosen_cnt_r) <= 32'(MAX_WINNERS))
    else $error("chosen list overflow");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit && have_r && !ctl.frame_start |=> chosen_cnt_r == $past(chosen_cnt_r) + CNT_W'(1))
    else $error("chosen list did not record winner");

  a_no_rechoose: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !s1_chosen_r)
    else $error("chosen cell taken again");

endmodule

### hw/rtl/top_k_map_peak_select.sv
// Top level: APB registers, map store and load, sequencer and compare unit.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | start && !busy         | in_map_value, in_frame_end
//  result   | out_strobe (1 cycle)   | out_win_x, out_win_y, out_found,
//           |                        | out_last_winner
//  config   | psel&penable&pwrite    | paddr (0x0 width, 0x4 height, 0x8 count),
//           |                        | pwdata, prdata, pready tied high
//
// A map value is taken each cycle that start is high and busy is low; a value
// marked frame_end starts N passes (N = winner_count, at most MAX_WINNERS),
// busy meanwhile. Each pass reads one map cell per cycle through the single
// store read port into one shared compare unit. Reset loads the register
// defaults and clears the load index; the store is not cleared. The receiver
// cannot stall: each result shows for one cycle.
module top_k_map_peak_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tkps_pkg::VAL_W-1:0]    in_map_value,
  input  logic                          in_frame_end,
  output logic                          out_strobe,
  output logic [tkps_pkg::COORD_W-1:0]  out_win_x,
  output logic [tkps_pkg::COORD_W-1:0]  out_win_y,
  output logic                          out_found,
  output logic                          out_last_winner,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tkps_pkg::APB_AW-1:0]   paddr,
  input  logic [tkps_pkg::APB_DW-1:0]   pwdata,
  output logic [tkps_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import tkps_pkg::*;

  logic [DIM_W-1:0]  map_width_r;
  logic [DIM_W-1:0]  map_height_r;
  logic [WC_W-1:0]   winner_count_r;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  frame_cfg_t        fcfg;
  logic              accept;
  logic              launch;
  logic [LOAD_W-1:0] load_idx_r, load_idx_nxt;
  logic              mem_we;
  logic [VAL_W-1:0]  map_mem [MAP_CELLS];
  logic [VAL_W-1:0]  rd_data_r;
  scan_t             scan;
  pass_ctl_t         ctl;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r    <= RST_MAP_WIDTH;
      map_height_r   <= RST_MAP_HEIGHT;
      winner_count_r <= RST_WINNER_COUNT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAP_WIDTH:    map_width_r    <= pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT:   map_height_r   <= pwdata[DIM_W-1:0];
        REG_WINNER_COUNT: winner_count_r <= pwdata[WC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAP_WIDTH:    prdata = APB_DW'(map_width_r);
      REG_MAP_HEIGHT:   prdata = APB_DW'(map_height_r);
      REG_WINNER_COUNT: prdata = APB_DW'(winner_count_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp dimensions and winner count
  assign fcfg.width  = (32'(map_width_r) > DIM_LIMIT) ? DIM_W'(DIM_LIMIT) : map_width_r;
  assign fcfg.height = (32'(map_height_r) > DIM_LIMIT) ? DIM_W'(DIM_LIMIT) : map_height_r;
  assign fcfg.count  = (32'(winner_count_r) > 32'(MAX_WINNERS)) ?
                       CNT_W'(MAX_WINNERS) : CNT_W'(winner_count_r);

  // Load map values; drop them once the store is full
  assign accept = start && !busy;
  assign launch = accept && in_frame_end;
  assign mem_we = accept && (load_idx_r < LOAD_W'(MAP_CELLS));

  always_comb begin
    load_idx_nxt = load_idx_r;
    if (mem_we) begin
      load_idx_nxt = load_idx_r + LOAD_W'(1);
    end
    if (launch) begin
      load_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
    end else begin
      load_idx_r <= load_idx_nxt;
    end
  end

  // Map store: write on load, registered read for the sweep
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[load_idx_r[ADDR_W-1:0]] <= in_map_value;
    end
    rd_data_r <= map_mem[ADDR_W'(scan.cell_idx)];
  end

  tkps_sweep u_sweep (
    .clk    (clk),
    .rst_n  (rst_n),
    .launch (launch),
    .cfg    (fcfg),
    .scan   (scan),
    .ctl    (ctl),
    .busy   (busy)
  );

  tkps_peak u_peak (
    .clk     (clk),
    .rst_n   (rst_n),
    .scan    (scan),
    .ctl     (ctl),
    .rd_data (rd_data_r),
    .win_x   (out_win_x),
    .win_y   (out_win_y),
    .found   (out_found)
  );

  assign out_strobe      = ctl.emit;
  assign out_last_winner = ctl.last;

  // Results only during a frame's passes; the last one ends the frame
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result outside of passes");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_winner |=> !busy)
    else $error("still busy after last winner");

  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    launch && (fcfg.count != '0) |=> busy && (load_idx_r == '0))
    else $error("frame end did not start passes");

endmodule
